>>> hw/rtl/sdrs_pkg.sv
// ----------------------------------------------------------------------------
// sdrs_pkg
// Shared types and codes for the shortest-seek-first disk request scheduler.
// ----------------------------------------------------------------------------
package sdrs_pkg;

   // Fixed field widths of the stream payloads
   localparam int ID_W        = 16;
   localparam int TIME_W      = 32;
   localparam int CYL_FIELD_W = 16;
   localparam int COUNT_W     = 5;
   localparam int STATUS_W    = 2;

   // Item kinds carried on the request tuser
   localparam logic OP_ARRIVE   = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   // Result codes carried on the response tuser
   localparam logic [STATUS_W-1:0] STATUS_QUEUED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SERVED  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE_RD,
      ST_MOVE,
      ST_FINISH
   } sdrs_state_type;

   // Control from the sequencer to the nearest-cylinder tracker
   typedef struct packed {
      logic load;   // an entry is on the read data this cycle
      logic first;  // it is the oldest entry, take it unconditionally
   } seek_ctl_type;

endpackage

>>> hw/rtl/sdrs_entry_ram.sv
// ----------------------------------------------------------------------------
// sdrs_entry_ram
// Pending request store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sdrs_entry_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 64,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sdrs_seek_min.sv
// ----------------------------------------------------------------------------
// sdrs_seek_min
// Nearest-cylinder tracker: folds one entry per cycle, while load is set, into the running best.
// ----------------------------------------------------------------------------
module sdrs_seek_min #(
   parameter int CYL_W   = 16,
   parameter int ENTRY_W = 64,
   parameter int IDX_W   = 4
) (
   input  logic                 clock,
   input  sdrs_pkg::seek_ctl_type ctl,
   input  logic [IDX_W-1:0]     idx,
   input  logic [CYL_W-1:0]     head,
   input  logic [ENTRY_W-1:0]   entry,
   output logic [IDX_W-1:0]     best_idx,
   output logic [CYL_W-1:0]     best_dist,
   output logic [ENTRY_W-1:0]   best_entry
);
   import sdrs_pkg::*;

   logic [CYL_W-1:0]   cyl;
   logic [CYL_W-1:0]   distance;
   logic               take;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [CYL_W-1:0]   best_dist_ff;
   logic [ENTRY_W-1:0] best_entry_ff;

   assign cyl      = entry[ENTRY_W-1 -: CYL_W];
   assign distance = (head >= cyl) ? (head - cyl) : (cyl - head);
   // strict less keeps the older entry on a tie
   assign take = ctl.load && (ctl.first || (distance < best_dist_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff   <= idx;
         best_dist_ff  <= distance;
         best_entry_ff <= entry;
      end
   end

   assign best_idx   = best_idx_ff;
   assign best_dist  = best_dist_ff;
   assign best_entry = best_entry_ff;

endmodule

>>> hw/rtl/sstf_disk_request_scheduler.sv
// Flow: an arrival, a drop or an empty completion goes from ST_IDLE straight to ST_FINISH.
// A completion goes through ST_SCAN, ST_MOVE_RD, ST_MOVE (if entries lie behind the nearest) and ST_FINISH:
// the scan reads one entry per cycle, then one entry moves per cycle to close the gap.
// Flow control: one item in flight, and ST_FINISH waits while the output register is full;
// the next transfer is taken once the result is in the output reg.
// Reset: clears the pending count, sequencer and output valid; the entry store is not cleared.
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler
// Shortest-seek-first disk request queue built around a single entry memory.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int CYLINDER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] req_tag, [47:16] arrival_time, [63:48] request_cylinder,
   // [79:64] head_cylinder
   input  logic [79:0] req_tdata,
   // [0] opcode
   input  logic [0:0]  req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] served_id, [47:16] served_arrival_time, [63:48] served_cylinder,
   // [79:64] seek_distance, [84:80] pending_count, [87:85] zero
   output logic [87:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser
);
   import sdrs_pkg::*;

   // Cylinders arrive as 16-bit fields; only the low CYLINDER_BITS of them (at most all 16) count
   localparam int CylW   = (CYLINDER_BITS < CYL_FIELD_W) ? CYLINDER_BITS : CYL_FIELD_W;
   localparam int EntryW = ID_W + TIME_W + CylW;
   localparam int AddrW  = $clog2(QUEUE_DEPTH);
   localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

   sdrs_state_type       state_ff, state_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [CntW-1:0]      ptr_ff, ptr_in;
   logic [CylW-1:0]      head_ff, head_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [87:0]          rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]           rsp_tuser_ff, rsp_tuser_in;

   // Request payload fields
   logic                 req_op;
   logic [ID_W-1:0]      req_id;
   logic [TIME_W-1:0]    req_time;
   logic [CYL_FIELD_W-1:0] req_cyl;
   logic [CYL_FIELD_W-1:0] req_head;

   // Memory and tracker hookup
   logic                 mem_we;
   logic [AddrW-1:0]     mem_waddr;
   logic [EntryW-1:0]    mem_wdata;
   logic [AddrW-1:0]     mem_raddr;
   logic [EntryW-1:0]    mem_rdata;
   seek_ctl_type         seek_ctl;
   logic [AddrW-1:0]     best_idx;
   logic [CylW-1:0]      best_dist;
   logic [EntryW-1:0]    best_entry;

   // Wide index arithmetic so that the compares never wrap
   logic [CntW:0]        ptr_p1;
   logic [CntW:0]        ptr_p2;
   logic [CntW:0]        best_p1;
   logic [CntW:0]        count_x;

   assign req_op   = req_tuser[0];
   assign req_id   = req_tdata[15:0];
   assign req_time = req_tdata[47:16];
   assign req_cyl  = req_tdata[63:48];
   assign req_head = req_tdata[79:64];

   assign ptr_p1  = (CntW + 1)'(ptr_ff) + (CntW + 1)'(1);
   assign ptr_p2  = (CntW + 1)'(ptr_ff) + (CntW + 1)'(2);
   assign best_p1 = (CntW + 1)'(best_idx) + (CntW + 1)'(1);
   assign count_x = (CntW + 1)'(count_ff);

   sdrs_entry_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .WIDTH  (EntryW),
      .ADDR_W (AddrW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   sdrs_seek_min #(
      .CYL_W   (CylW),
      .ENTRY_W (EntryW),
      .IDX_W   (AddrW)
   ) u_seek_min (
      .clock      (clock),
      .ctl        (seek_ctl),
      .idx        (ptr_ff[AddrW-1:0]),
      .head       (head_ff),
      .entry      (mem_rdata),
      .best_idx   (best_idx),
      .best_dist  (best_dist),
      .best_entry (best_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      head_ff      <= head_in;
      status_ff    <= status_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      head_in        = head_ff;
      status_in      = status_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tuser_in   = rsp_tuser_ff;
      // drop valid once the consumer takes the transfer
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      req_tready     = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = ptr_ff[AddrW-1:0];
      mem_wdata      = mem_rdata;
      mem_raddr      = ptr_ff[AddrW-1:0];
      seek_ctl       = '0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               head_in = req_head[CylW-1:0];
               if (req_op == OP_ARRIVE) begin
                  if (count_ff == DepthC) begin
                     status_in = STATUS_DROPPED;
                  end else begin
                     // append at the tail, stamped with its arrival time
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[AddrW-1:0];
                     mem_wdata = {req_cyl[CylW-1:0], req_time, req_id};
                     count_in  = count_ff + CntW'(1);
                     status_in = STATUS_QUEUED;
                  end
                  state_in = ST_FINISH;
               end else if (count_ff == '0) begin
                  status_in = STATUS_EMPTY;
                  state_in  = ST_FINISH;
               end else begin
                  // start the scan at the oldest entry
                  mem_raddr = '0;
                  ptr_in    = '0;
                  state_in  = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // fold the entry read last cycle, fetch the next one
            seek_ctl.load  = 1'b1;
            seek_ctl.first = (ptr_ff == '0);
            mem_raddr      = ptr_p1[AddrW-1:0];
            if (ptr_p1 == count_x) begin
               state_in = ST_MOVE_RD;
            end else begin
               ptr_in = ptr_p1[CntW-1:0];
            end
         end

         ST_MOVE_RD: begin
            // fetch the entry behind the chosen one, if any
            ptr_in    = CntW'(best_idx);
            mem_raddr = best_p1[AddrW-1:0];
            if (best_p1 < count_x) begin
               state_in = ST_MOVE;
            end else begin
               count_in  = count_ff - CntW'(1);
               status_in = STATUS_SERVED;
               state_in  = ST_FINISH;
            end
         end

         ST_MOVE: begin
            // shift one younger entry down to close the gap
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AddrW-1:0];
            mem_wdata = mem_rdata;
            mem_raddr = ptr_p2[AddrW-1:0];
            if (ptr_p2 < count_x) begin
               ptr_in = ptr_p1[CntW-1:0];
            end else begin
               count_in  = count_ff - CntW'(1);
               status_in = STATUS_SERVED;
               state_in  = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // hold the result until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = status_ff;
               rsp_tdata_in  = '0;
               rsp_tdata_in[84:80] = COUNT_W'(32'(count_ff));
               if (status_ff == STATUS_SERVED) begin
                  rsp_tdata_in[15:0]  = best_entry[ID_W-1:0];
                  rsp_tdata_in[47:16] = best_entry[ID_W +: TIME_W];
                  rsp_tdata_in[63:48] = CYL_FIELD_W'(best_entry[EntryW-1 -: CylW]);
                  rsp_tdata_in[79:64] = CYL_FIELD_W'(best_dist);
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef NO_ASSERTIONS
   // The pending count never runs past the queue depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthC)
      else $error("pending count above queue depth");

   // A transfer in starts work: the block is busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new request taken while one is in work");

   // Gap closing only writes inside the occupied part of the queue
   a_move_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE) |-> (ptr_p1 < count_x))
      else $error("entry move outside the pending range");

   // A served result always frees a slot
   a_served_frees: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && status_ff == STATUS_SERVED) |-> (count_ff < DepthC))
      else $error("served result with a full queue");
`endif

endmodule
